// ===== rtl/sem_pkg.sv =====
// Shared constants, types and kernel tables of the Sobel edge magnitude block.
package sem_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int PIX_W      = 8;
  localparam int RGB_W      = 3 * PIX_W;
  localparam int W_REG_W    = 11;
  localparam int H_REG_W    = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  localparam logic [W_REG_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [H_REG_W-1:0] RST_IMAGE_HEIGHT = 13'd480;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int TAPS        = 9;
  localparam int TAP_W       = 4;
  localparam int G_W         = 12;
  localparam int SQ_W        = 22;
  localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

  typedef struct packed {
    logic wr;
    logic rel;
    logic top;
    logic bottom;
    logic left;
    logic right;
  } sem_flags_t;

  // Row offset of a window tap: -1, 0 or +1.
  function automatic logic signed [1:0] tap_dr(input logic [TAP_W-1:0] k);
    logic signed [1:0] r;
    case (k)
      4'd0, 4'd1, 4'd2: r = -2'sd1;
      4'd3, 4'd4, 4'd5: r = 2'sd0;
      default:          r = 2'sd1;
    endcase
    return r;
  endfunction

  // Column offset of a window tap: -1, 0 or +1.
  function automatic logic signed [1:0] tap_dc(input logic [TAP_W-1:0] k);
    logic signed [1:0] r;
    case (k)
      4'd0, 4'd3, 4'd6: r = -2'sd1;
      4'd1, 4'd4, 4'd7: r = 2'sd0;
      default:          r = 2'sd1;
    endcase
    return r;
  endfunction

  function automatic logic signed [2:0] kern_x(input logic [TAP_W-1:0] k);
    logic signed [2:0] r;
    case (k)
      4'd0, 4'd6: r = -3'sd1;
      4'd3:       r = -3'sd2;
      4'd2, 4'd8: r = 3'sd1;
      4'd5:       r = 3'sd2;
      default:    r = 3'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [2:0] kern_y(input logic [TAP_W-1:0] k);
    logic signed [2:0] r;
    case (k)
      4'd0, 4'd2: r = -3'sd1;
      4'd1:       r = -3'sd2;
      4'd6, 4'd8: r = 3'sd1;
      4'd7:       r = 3'sd2;
      default:    r = 3'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/sem_pix_if.sv =====
// Input channel: RGB pixel or drain command.
interface sem_pix_if;
  import sem_pkg::*;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [PIX_W-1:0] in_red;
  logic [PIX_W-1:0] in_green;
  logic [PIX_W-1:0] in_blue;

  modport source (output valid, cmd, in_red, in_green, in_blue, input ready);
  modport sink (input valid, cmd, in_red, in_green, in_blue, output ready);
endinterface

// ===== rtl/sem_edge_if.sv =====
// Output channel: per-channel edge magnitude and end of frame.
interface sem_edge_if;
  import sem_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] edge_red;
  logic [PIX_W-1:0] edge_green;
  logic [PIX_W-1:0] edge_blue;
  logic             frame_end;

  modport source (output valid, edge_red, edge_green, edge_blue, frame_end, input ready);
  modport sink (input valid, edge_red, edge_green, edge_blue, frame_end, output ready);
endinterface

// ===== rtl/sem_fifo.sv =====
// Small register queue between the front and the back.
module sem_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output logic [DW-1:0] data_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] store_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = store_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) store_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (do_pop)  rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
    end
  end
endmodule

// ===== rtl/sem_front.sv =====
// Front end: takes transactions, tracks frame position and queues work.
module sem_front #(
  parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF,
  parameter int DW         = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  sem_pix_if.sink                          pix_in,
  input  logic                             cfg_we_i,
  input  logic [sem_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output logic [DW-1:0]                    q_data_o
);
  import sem_pkg::*;

  localparam int RING = 2 * MAX_WIDTH + 3;
  localparam int PW   = $clog2(RING);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int NW   = $clog2(MAX_WIDTH + 2);

  logic [W_REG_W-1:0] wreg_q;
  logic [H_REG_W-1:0] hreg_q;
  logic [WW-1:0]      cur_w_q, w;
  logic [HW-1:0]      cur_h_q, h;
  logic [CW-1:0]      in_col_q, out_col_q;
  logic [RW-1:0]      in_row_q, out_row_q;
  logic [NW-1:0]      pend_q;
  logic [PW-1:0]      wptr_q, optr_q, waddr;
  logic               done_q;
  logic [WW-1:0]      w_cl;
  logic [HW-1:0]      h_cl;
  logic               acc, pixel, start, rel, last;
  sem_flags_t         fl;

  always_comb begin
    if (wreg_q == '0) w_cl = WW'(1);
    else if (32'(wreg_q) > MAX_WIDTH) w_cl = WW'(MAX_WIDTH);
    else w_cl = WW'(wreg_q);
    if (hreg_q == '0) h_cl = HW'(1);
    else if (32'(hreg_q) > MAX_HEIGHT) h_cl = HW'(MAX_HEIGHT);
    else h_cl = HW'(hreg_q);
  end

  assign pix_in.ready = !q_full_i;
  assign acc   = pix_in.valid && !q_full_i;
  assign pixel = (pix_in.cmd == CMD_PIXEL) && !done_q;
  assign start = pixel && (in_row_q == '0) && (in_col_q == '0);
  assign w     = start ? w_cl : cur_w_q;
  assign h     = start ? h_cl : cur_h_q;
  assign waddr = start ? '0 : wptr_q;
  assign rel   = pixel ? (pend_q > NW'(w)) : done_q;

  always_comb begin
    fl.wr     = pixel;
    fl.rel    = rel;
    fl.top    = (out_row_q == '0);
    fl.bottom = (HW'(out_row_q) == h - 1'b1);
    fl.left   = (out_col_q == '0);
    fl.right  = (WW'(out_col_q) == w - 1'b1);
  end
  assign last = fl.bottom && fl.right;

  assign q_push_o = acc && (pixel || rel);
  assign q_data_o = {fl, pix_in.in_red, pix_in.in_green, pix_in.in_blue, waddr, optr_q, w};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wreg_q    <= RST_IMAGE_WIDTH;
      hreg_q    <= RST_IMAGE_HEIGHT;
      cur_w_q   <= WW'(MAX_WIDTH);
      cur_h_q   <= HW'(MAX_HEIGHT);
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      pend_q    <= '0;
      wptr_q    <= '0;
      optr_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IMAGE_WIDTH:  wreg_q <= cfg_wdata_i[W_REG_W-1:0];
          CFG_IMAGE_HEIGHT: hreg_q <= cfg_wdata_i[H_REG_W-1:0];
          default: ;
        endcase
      end
      if (acc) begin
        if (start) begin
          cur_w_q <= w_cl;
          cur_h_q <= h_cl;
        end
        if (pixel) begin
          wptr_q <= (waddr == PW'(RING - 1)) ? '0 : waddr + 1'b1;
          if (WW'(in_col_q) == w - 1'b1) begin
            in_col_q <= '0;
            if (HW'(in_row_q) == h - 1'b1) done_q <= 1'b1;
            else in_row_q <= in_row_q + 1'b1;
          end else begin
            in_col_q <= in_col_q + 1'b1;
          end
        end
        pend_q <= pend_q + NW'(pixel) - NW'(rel);
        if (rel) begin
          if (last) begin
            // frame complete: restart all counters
            in_col_q  <= '0;
            in_row_q  <= '0;
            out_col_q <= '0;
            out_row_q <= '0;
            pend_q    <= '0;
            optr_q    <= '0;
            done_q    <= 1'b0;
          end else begin
            optr_q <= (optr_q == PW'(RING - 1)) ? '0 : optr_q + 1'b1;
            if (fl.right) begin
              out_col_q <= '0;
              out_row_q <= out_row_q + 1'b1;
            end else begin
              out_col_q <= out_col_q + 1'b1;
            end
          end
        end
      end
    end
  end
endmodule

// ===== rtl/sem_back.sv =====
// Back end: line store, window gather, gradient sums and rounded square root.
module sem_back #(
  parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF,
  parameter int DW        = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  logic [DW-1:0] q_data_i,
  output logic          q_pop_o,
  sem_edge_if.source    edge_out
);
  import sem_pkg::*;

  localparam int RING = 2 * MAX_WIDTH + 3;
  localparam int PW   = $clog2(RING);
  localparam int WW   = $clog2(MAX_WIDTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_TAIL = 3'd2;
  localparam logic [2:0] ST_SQ   = 3'd3;
  localparam logic [2:0] ST_ROOT = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  sem_flags_t       q_fl, fl_q;
  logic [RGB_W-1:0] q_pix, rdata_q;
  logic [PW-1:0]    q_waddr, q_optr, optr_q, raddr;
  logic [WW-1:0]    q_w, w_q;

  logic [RGB_W-1:0] mem_q [RING];

  logic [2:0]       state_q;
  logic [TAP_W-1:0] k_q, tk_q;
  logic             tv_q, tm_q, mask;
  logic signed [1:0] dr, dc;
  logic signed [PW+1:0] t;

  logic signed [G_W-1:0] gx_q [3];
  logic signed [G_W-1:0] gy_q [3];
  logic [SQ_W-1:0]       s_q [3];
  logic [SQ_W-1:0]       res_q [3];
  logic [SQ_W-1:0]       bit_q;
  logic                  ov_q, load, pop;
  logic [PIX_W-1:0]      mag [3];
  logic [PIX_W-1:0]      mag_q [3];
  logic                  fe_q;

  assign {q_fl, q_pix, q_waddr, q_optr, q_w} = q_data_i;
  assign pop      = (state_q == ST_IDLE) && q_valid_i;
  assign q_pop_o  = pop;

  // neighbor address around the center pointer, wrapped into the ring
  assign dr = tap_dr(k_q);
  assign dc = tap_dc(k_q);
  always_comb begin
    t = signed'({2'b00, optr_q}) + signed'({{PW{dc[1]}}, dc});
    if (dr < 0) t = t - signed'({{(PW+2-WW){1'b0}}, w_q});
    else if (dr > 0) t = t + signed'({{(PW+2-WW){1'b0}}, w_q});
    if (t < 0) t = t + (PW+2)'(RING);
    else if (t >= (PW+2)'(RING)) t = t - (PW+2)'(RING);
    raddr = t[PW-1:0];
    mask = !((dr < 0) && fl_q.top) && !((dr > 0) && fl_q.bottom) &&
           !((dc < 0) && fl_q.left) && !((dc > 0) && fl_q.right);
  end

  always_ff @(posedge clk_i) begin
    if (pop && q_fl.wr) mem_q[q_waddr] <= q_pix;
    rdata_q <= mem_q[raddr];
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [SQ_W-1:0] r;
      r = (s_q[c] > res_q[c]) ? res_q[c] + 1'b1 : res_q[c];
      mag[c] = (r > SQ_W'(MAG_MAX)) ? MAG_MAX : r[PIX_W-1:0];
    end
  end
  assign load = (state_q == ST_DONE) && (!ov_q || edge_out.ready);

  always_ff @(posedge clk_i) begin
    if (pop) begin
      optr_q <= q_optr;
      w_q    <= q_w;
      fl_q   <= q_fl;
    end
    tk_q <= k_q;
    tm_q <= mask;
    for (int c = 0; c < 3; c++) begin
      if (pop) begin
        gx_q[c] <= '0;
        gy_q[c] <= '0;
      end else if (tv_q) begin
        logic signed [G_W-1:0] v;
        v = tm_q ? signed'(G_W'(rdata_q[RGB_W-1-PIX_W*c -: PIX_W])) : '0;
        gx_q[c] <= gx_q[c] + G_W'(v * G_W'(kern_x(tk_q)));
        gy_q[c] <= gy_q[c] + G_W'(v * G_W'(kern_y(tk_q)));
      end
      if (state_q == ST_SQ) begin
        s_q[c]   <= SQ_W'(SQ_W'(gx_q[c]) * SQ_W'(gx_q[c])) +
                    SQ_W'(SQ_W'(gy_q[c]) * SQ_W'(gy_q[c]));
        res_q[c] <= '0;
      end else if (state_q == ST_ROOT) begin
        if (s_q[c] >= res_q[c] + bit_q) begin
          s_q[c]   <= s_q[c] - (res_q[c] + bit_q);
          res_q[c] <= (res_q[c] >> 1) + bit_q;
        end else begin
          res_q[c] <= res_q[c] >> 1;
        end
      end
      if (load) mag_q[c] <= mag[c];
    end
    if (state_q == ST_SQ) bit_q <= SQ_W'(1) << (SQ_W - 2);
    else if (state_q == ST_ROOT) bit_q <= bit_q >> 2;
    if (load) fe_q <= fl_q.bottom && fl_q.right;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      tv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      tv_q <= (state_q == ST_READ);
      if (edge_out.ready) ov_q <= 1'b0;
      if (load) ov_q <= 1'b1;
      case (state_q)
        ST_IDLE: begin
          k_q <= '0;
          if (pop && q_fl.rel) state_q <= ST_READ;
        end
        ST_READ: begin
          k_q <= k_q + 1'b1;
          if (k_q == TAP_W'(TAPS - 1)) state_q <= ST_TAIL;
        end
        ST_TAIL: state_q <= ST_SQ;
        ST_SQ:   state_q <= ST_ROOT;
        ST_ROOT: if (bit_q[0]) state_q <= ST_DONE;
        ST_DONE: if (load) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign edge_out.valid      = ov_q;
  assign edge_out.edge_red   = mag_q[0];
  assign edge_out.edge_green = mag_q[1];
  assign edge_out.edge_blue  = mag_q[2];
  assign edge_out.frame_end  = fe_q;
endmodule

// ===== rtl/sobel_edge_magnitude_rgb.sv =====
// Top level of the streaming 3x3 Sobel edge magnitude block for RGB pixels.
//
// Usage: set image_width (index 0) and image_height (index 1) through the
// configuration write port while the block is idle; the geometry is taken at
// the first pixel of each frame. Send pixels in raster order on pix_in with
// cmd = pixel. The pixel at linear position p releases the result for
// position p-width-1. After the whole frame, send width+1 drain transactions
// (cmd = drain) to release the rest; frame_end marks the last result.
// The result of a releasing transaction passes through the queue, nine reads
// of the line store, a tail step that finishes the sums, squaring, an
// 11-step rounded square root and the output load before it is valid on
// edge_out. Pixels that release nothing are only written to the line store;
// the back takes a new queue entry only when idle, so it finishes the window
// reads and the root of one result before it starts the next.
// A four-entry queue lets the front keep taking pixels while the back works.
// Reset clears counters, queue and output valid and restores the default
// geometry (640 x 480); the line store is not cleared. When the receiver
// stalls, the result holds on edge_out and the back waits; the queue then
// fills and pix_in.ready drops.
module sobel_edge_magnitude_rgb #(
  parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  sem_pix_if.sink                        pix_in,
  sem_edge_if.source                     edge_out,
  input  logic                           cfg_we_i,
  input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import sem_pkg::*;

  localparam int RING = 2 * MAX_WIDTH + 3;
  localparam int PW   = $clog2(RING);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int DW   = $bits(sem_flags_t) + RGB_W + 2 * PW + WW;

  logic          q_push, q_full, q_pop, q_valid;
  logic [DW-1:0] q_in, q_out;

  sem_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .DW        (DW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_in     (pix_in),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  sem_fifo #(
    .DW   (DW),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_out)
  );

  sem_back #(
    .MAX_WIDTH(MAX_WIDTH),
    .DW       (DW)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_data_i (q_out),
    .q_pop_o  (q_pop),
    .edge_out (edge_out)
  );
endmodule
